[rtl/core/dili_pkg.sv]
// shared types and constants for the display init list interpreter
// no dependencies; used by the channel interfaces and all core modules
`default_nettype none

package dili_pkg;

   typedef enum logic [1:0] {
      ACT_NONE     = 2'd0,
      ACT_SEND_CMD = 2'd1,
      ACT_SEND_DAT = 2'd2,
      ACT_WAIT     = 2'd3
   } action_type;

   localparam logic [7:0] DELAY_FLAG_BIT  = 8'h80;
   localparam logic [7:0] LONG_DELAY_CODE = 8'd255;
   localparam logic [8:0] LONG_DELAY_MS   = 9'd500;

   typedef struct packed {
      action_type action;
      logic [7:0] send_byte;
      logic [8:0] wait_ms;
      logic       list_done;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/dili_stream_if.sv]
// valid/ready channel interfaces for list byte requests and action responses
// depends on dili_pkg for the response field types
`default_nettype none

interface dili_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] list_byte;

   modport source (output valid, output list_byte, input ready);
   modport sink (input valid, input list_byte, output ready);
endinterface

interface dili_rsp_if;
   logic                valid;
   logic                ready;
   dili_pkg::action_type action;
   logic [7:0]          send_byte;
   logic [8:0]          wait_ms;
   logic                list_done;

   modport source (output valid, output action, output send_byte, output wait_ms,
                   output list_done, input ready);
   modport sink (input valid, input action, input send_byte, input wait_ms,
                 input list_done, output ready);
endinterface

`default_nettype wire

[rtl/core/dili_seq.sv]
// list parser state machine: tracks phase and counters, decodes one byte per request
// depends on dili_pkg for the action codes and the response struct
`default_nettype none

module dili_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        list_byte,
   output dili_pkg::rsp_type      result
);

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_CMD   = 3'd1,
      PH_ARGC  = 3'd2,
      PH_ARGS  = 3'd3,
      PH_DELAY = 3'd4
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] commands_ff, commands_in;
   logic [6:0] args_ff, args_in;
   logic       delay_ff, delay_in;

   logic [7:0] cmd_dec;
   logic [6:0] args_dec;
   logic       cmd_last;

   assign cmd_dec  = commands_ff - 8'd1;
   assign args_dec = args_ff - 7'd1;
   assign cmd_last = (cmd_dec == 8'd0);

   always_comb begin
      phase_in    = phase_ff;
      commands_in = commands_ff;
      args_in     = args_ff;
      delay_in    = delay_ff;
      result      = '{action: dili_pkg::ACT_NONE, send_byte: 8'd0, wait_ms: 9'd0,
                      list_done: 1'b0};
      unique case (phase_ff)
         PH_CMD: begin
            result.action    = dili_pkg::ACT_SEND_CMD;
            result.send_byte = list_byte;
            phase_in         = PH_ARGC;
         end
         PH_ARGC: begin
            args_in  = list_byte[6:0];
            delay_in = |(list_byte & dili_pkg::DELAY_FLAG_BIT);
            if (list_byte[6:0] != 7'd0) begin
               phase_in = PH_ARGS;
            end else if (|(list_byte & dili_pkg::DELAY_FLAG_BIT)) begin
               phase_in = PH_DELAY;
            end else begin
               commands_in      = cmd_dec;
               args_in          = 7'd0;
               delay_in         = 1'b0;
               result.list_done = cmd_last;
               phase_in         = cmd_last ? PH_COUNT : PH_CMD;
            end
         end
         PH_ARGS: begin
            result.action    = dili_pkg::ACT_SEND_DAT;
            result.send_byte = list_byte;
            args_in          = args_dec;
            if (args_dec == 7'd0) begin
               if (delay_ff) begin
                  phase_in = PH_DELAY;
               end else begin
                  commands_in      = cmd_dec;
                  delay_in         = 1'b0;
                  result.list_done = cmd_last;
                  phase_in         = cmd_last ? PH_COUNT : PH_CMD;
               end
            end
         end
         PH_DELAY: begin
            result.action    = dili_pkg::ACT_WAIT;
            result.wait_ms   = (list_byte == dili_pkg::LONG_DELAY_CODE) ?
                               dili_pkg::LONG_DELAY_MS : {1'b0, list_byte};
            commands_in      = cmd_dec;
            args_in          = 7'd0;
            delay_in         = 1'b0;
            result.list_done = cmd_last;
            phase_in         = cmd_last ? PH_COUNT : PH_CMD;
         end
         default: begin
            // command count byte, also taken for any stray phase code
            commands_in      = list_byte;
            args_in          = 7'd0;
            delay_in         = 1'b0;
            result.list_done = (list_byte == 8'd0);
            phase_in         = (list_byte == 8'd0) ? PH_COUNT : PH_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         commands_ff <= 8'd0;
         args_ff     <= 7'd0;
         delay_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         commands_ff <= commands_in;
         args_ff     <= args_in;
         delay_ff    <= delay_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/display_init_list_interpreter.sv]
// display init list interpreter top level: parser plus output register with skid stage
// an accepted byte's response is registered in the output register or skid stage
// throughput: one list byte per cycle while the skid stage is empty
// the skid stage lets one more request in while a response is stalled
// reset is synchronous, active high; parser returns to expecting a command count
`default_nettype none

module display_init_list_interpreter (
   input  wire logic clock,
   input  wire logic reset,
   dili_req_if.sink   req_ch,
   dili_rsp_if.source rsp_ch
);

   dili_pkg::rsp_type step_res;
   dili_pkg::rsp_type out_ff, out_in;
   dili_pkg::rsp_type skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              req_acc;
   logic              out_take;

   assign req_ch.ready = ~skid_valid_ff & ~reset;
   assign req_acc      = req_ch.valid & ~skid_valid_ff & ~reset;
   assign out_take     = out_valid_ff & rsp_ch.ready;

   dili_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_acc),
      .list_byte (req_ch.list_byte),
      .result    (step_res)
   );

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_acc) begin
         if (!out_valid_ff || out_take) begin
            out_in       = step_res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.action    = out_ff.action;
   assign rsp_ch.send_byte = out_ff.send_byte;
   assign rsp_ch.wait_ms   = out_ff.wait_ms;
   assign rsp_ch.list_done = out_ff.list_done;

`ifndef SYNTHESIS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a response while output register is empty");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> out_valid_ff)
      else $error("accepted request left no response");

   a_cmd_never_done: assert property (@(posedge clock) disable iff (reset)
      !(rsp_ch.valid && rsp_ch.list_done && rsp_ch.action == dili_pkg::ACT_SEND_CMD))
      else $error("command byte marked as list end");

   a_wait_only_on_delay: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.action != dili_pkg::ACT_WAIT) |-> (rsp_ch.wait_ms == 9'd0))
      else $error("nonzero wait on a non-delay response");
`endif

endmodule

`default_nettype wire
